>>> rtl/i2dt_pkg.sv
// Shared types and constants for the integer to decimal text converter.
package i2dt_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned PosWidth   = 24;
	localparam int unsigned CodeWidth  = 6;
	localparam int unsigned MaxDigits  = 10;
	localparam int unsigned DigitIdxW  = 4;
	localparam int unsigned StepCntW   = 5;

	localparam logic [CodeWidth-1:0] CodeZero  = 6'd48;
	localparam logic [CodeWidth-1:0] CodeMinus = 6'd45;

	typedef struct packed {
		logic signed [ValueWidth-1:0] value;
		logic [PosWidth-1:0]          base_position;
	} item_t;

	typedef struct packed {
		logic [CodeWidth-1:0] char_code;
		logic [PosWidth-1:0]  char_position;
		logic                 is_last;
	} result_t;

	typedef enum logic [2:0] {
		StIdle,
		StConvert,
		StSkip,
		StSign,
		StDigits
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic skip;
		logic emit_sign;
		logic emit_digit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic shift_done;
		logic top_zero;
		logic idx_zero;
		logic negative;
	} dp_status_t;

endpackage

>>> rtl/i2dt_ctrl.sv
// Controller state machine: sequences conversion, zero skipping and character output.
module i2dt_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  i2dt_pkg::dp_status_t   status,
	output i2dt_pkg::ctrl_cmd_t    cmd,
	output logic                   busy,
	output logic                   strobe
);
	import i2dt_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			StIdle: begin
				if (start) state_next = StConvert;
			end
			StConvert: begin
				if (status.shift_done) state_next = StSkip;
			end
			StSkip: begin
				// leave once the top digit is significant or only the units digit is left
				if (!status.top_zero || status.idx_zero) begin
					state_next = status.negative ? StSign : StDigits;
				end
			end
			StSign: begin
				state_next = StDigits;
			end
			StDigits: begin
				if (status.idx_zero) state_next = StIdle;
			end
			default: state_next = StIdle;
		endcase
	end

	always_comb begin
		cmd    = '0;
		busy   = 1'b1;
		strobe = 1'b0;
		case (state_q)
			StIdle: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			StConvert: begin
				cmd.shift = 1'b1;
			end
			StSkip: begin
				cmd.skip = status.top_zero && !status.idx_zero;
			end
			StSign: begin
				cmd.emit_sign = 1'b1;
				strobe        = 1'b1;
			end
			StDigits: begin
				cmd.emit_digit = 1'b1;
				strobe         = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

>>> rtl/i2dt_dpath.sv
// Datapath: magnitude, shift-add-3 BCD register, digit pointer and position counter.
module i2dt_dpath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  i2dt_pkg::item_t      item,
	input  i2dt_pkg::ctrl_cmd_t  cmd,
	output i2dt_pkg::dp_status_t status,
	output i2dt_pkg::result_t    result
);
	import i2dt_pkg::*;

	logic [ValueWidth-1:0]           mag_q;
	logic [MaxDigits-1:0][3:0]       bcd_q;
	logic [MaxDigits-1:0][3:0]       bcd_adj;
	logic [MaxDigits*4:0]            bcd_shift;
	logic [StepCntW-1:0]             cnt_q;
	logic [DigitIdxW-1:0]            idx_q;
	logic                            neg_q;
	logic [PosWidth-1:0]             pos_q;
	logic [3:0]                      cur_digit;
	logic [ValueWidth-1:0]           raw;

	assign raw = item.value;

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < MaxDigits; i++) begin
			bcd_adj[i] = (bcd_q[i] >= 4'd5) ? (bcd_q[i] + 4'd3) : bcd_q[i];
		end
	end

	// shift the next magnitude bit in; the top digit never exceeds two, so drop its high bit
	assign bcd_shift = {bcd_adj, mag_q[ValueWidth-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q <= '0;
			cnt_q <= '0;
			idx_q <= '0;
			neg_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				neg_q <= raw[ValueWidth-1];
				mag_q <= raw[ValueWidth-1] ? ('0 - raw) : raw;
				cnt_q <= '0;
				idx_q <= DigitIdxW'(MaxDigits - 1);
			end else if (cmd.shift) begin
				mag_q <= {mag_q[ValueWidth-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end else if (cmd.skip || (cmd.emit_digit && idx_q != '0)) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bcd_q <= '0;
			pos_q <= item.base_position;
		end else begin
			if (cmd.shift) begin
				bcd_q <= bcd_shift[MaxDigits*4-1:0];
			end
			if (cmd.emit_sign || cmd.emit_digit) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	assign cur_digit = bcd_q[idx_q];

	assign status.shift_done = (cnt_q == StepCntW'(ValueWidth - 1));
	assign status.top_zero   = (cur_digit == 4'd0);
	assign status.idx_zero   = (idx_q == '0);
	assign status.negative   = neg_q;

	assign result.char_code     = cmd.emit_sign ? CodeMinus : (CodeZero + {2'b00, cur_digit});
	assign result.char_position = pos_q;
	assign result.is_last       = cmd.emit_digit && (idx_q == '0);

endmodule

>>> rtl/int32_to_decimal_text.sv
// Top level of the signed 32-bit integer to decimal character converter.
// Order: the 32-step shift-add-3 loop, the leading-zero skip, then the sign and digits
// at one character per cycle. A new item is taken only while busy is low, once the
// last character of the previous item is out.
// Results are strobed for one cycle each; the receiver cannot stall.
// Reset (arst_n low, asynchronous) returns the controller to idle with busy low.
module int32_to_decimal_text (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  i2dt_pkg::item_t     item,
	output logic                busy,
	output logic                strobe,
	output i2dt_pkg::result_t   result
);
	import i2dt_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	i2dt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.strobe (strobe)
	);

	i2dt_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule

>>> bench/i2dt_char_check_pkg.sv
// Expected-character store and checker for the decimal text converter bench.
`timescale 1ns / 100ps

package i2dt_char_check_pkg;

	import i2dt_pkg::*;

	localparam int unsigned ReportLimit = 10;

	class char_run_checker;

		result_t expected_chars[$];
		int      char_errors;
		int      chars_checked;

		function new();
			char_errors   = 0;
			chars_checked = 0;
		endfunction

		// Render the accepted value as text and queue one expected character per code.
		function void note_value(item_t it);
			logic [ValueWidth:0]  magnitude;
			logic [DigitIdxW-1:0] digits [MaxDigits];
			logic [PosWidth-1:0]  pos;
			logic                 negative;
			int                   n_digits;
			int                   total;
			int                   idx;
			result_t              ch;

			negative = it.value[ValueWidth-1];
			// widen before negating so the most negative value keeps its magnitude
			magnitude = negative ? ((ValueWidth+1)'(0) - {1'b1, it.value})
			                     : {1'b0, it.value};
			n_digits = 0;
			do begin
				digits[n_digits] = DigitIdxW'(magnitude % 10);
				magnitude = magnitude / 10;
				n_digits++;
			end while (magnitude != 0 && n_digits < MaxDigits);

			total = n_digits + int'(negative);
			pos   = it.base_position;
			idx   = 0;
			if (negative) begin
				ch.char_code     = CodeMinus;
				ch.char_position = pos;
				ch.is_last       = (total == 1);
				expected_chars.push_back(ch);
				pos++;
				idx++;
			end
			for (int d = n_digits - 1; d >= 0; d--) begin
				ch.char_code     = CodeZero + CodeWidth'(digits[d]);
				ch.char_position = pos;
				ch.is_last       = (idx + 1 == total);
				expected_chars.push_back(ch);
				pos++;
				idx++;
			end
		endfunction

		function void check_char(result_t got);
			result_t want;

			chars_checked++;
			if (expected_chars.size() == 0) begin
				if (char_errors < ReportLimit)
					$display("%0t: unexpected char code %0d pos %0d last %0b", $time,
						got.char_code, got.char_position, got.is_last);
				char_errors++;
				return;
			end
			want = expected_chars.pop_front();
			if (got.char_code !== want.char_code || got.char_position !== want.char_position
					|| got.is_last !== want.is_last) begin
				if (char_errors < ReportLimit)
					$display("%0t: char mismatch: want code %0d pos %0d last %0b, got code %0d pos %0d last %0b",
						$time, want.char_code, want.char_position, want.is_last,
						got.char_code, got.char_position, got.is_last);
				char_errors++;
			end
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

	endclass

endpackage

>>> bench/int32_to_decimal_text_test.sv
// Self-checking bench for the signed 32-bit integer to decimal text converter.
`timescale 1ns / 100ps

module int32_to_decimal_text_test;

	import i2dt_pkg::*;
	import i2dt_char_check_pkg::*;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 60;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    strobe;
	result_t result;

	char_run_checker board;
	int idle_pct;
	int cycle_count = 0;
	int values_sent;
	int negatives_sent;
	int wraps_sent;

	int32_to_decimal_text u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.strobe (strobe),
		.result (result)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("int32_to_decimal_text_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && strobe)
			board.check_char(result);
	end

	// Offer one item, idling at random, until the block takes it.
	task automatic send_value(input logic signed [ValueWidth-1:0] v, input logic [PosWidth-1:0] p);
		item_t it;
		bit    taken;

		it.value         = v;
		it.base_position = p;
		taken = 0;
		while (!taken) begin
			@(negedge clk);
			if ($urandom_range(99) < idle_pct) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				item  <= it;
				@(posedge clk);
				if (!busy) begin
					board.note_value(it);
					taken = 1;
				end
			end
		end
		values_sent++;
		if (v < 0)
			negatives_sent++;
		if (int'(p) + 11 > (1 << PosWidth))
			wraps_sent++;
	endtask

	// Hold off until every queued character has come out and the block is idle.
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (board.pending() != 0 || busy)
			@(posedge clk);
	endtask

	task automatic send_random(input int count);
		longint lo;
		longint hi;
		longint mag;
		int     n;
		logic signed [ValueWidth-1:0] v;
		logic [PosWidth-1:0] p;

		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3))
				0: v = $urandom;
				default: begin
					// pick a digit count first so short and long runs both appear
					n   = $urandom_range(1, 10);
					lo  = (n == 1) ? 0 : 10 ** (n - 1);
					hi  = (n == 10) ? 64'd2147483648 : (10 ** n) - 1;
					mag = lo + ($urandom % (hi - lo + 1));
					v   = $urandom_range(1) ? ValueWidth'(-mag) : ValueWidth'(mag);
				end
			endcase
			p = ($urandom_range(7) == 0) ? PosWidth'(24'hFFFFFF - $urandom_range(12))
			                             : PosWidth'($urandom);
			send_value(v, p);
			if ($urandom_range(29) == 0)
				wait_drained();
		end
	endtask

	initial begin
		board          = new();
		values_sent    = 0;
		negatives_sent = 0;
		wraps_sent     = 0;
		idle_pct       = 38;
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		send_value(0, 0);
		send_value(1, 24'hFFFFFF);
		send_value(-1, 24'hFFFFFF);
		send_value(9, 24'h000001);
		send_value(10, 24'h123456);
		send_value(-10, 24'hFFFFFE);
		send_value(99, 24'h800000);
		send_value(100, 24'h7FFFFF);
		send_value(32'sh7FFFFFFF, 24'hFFFFF6);
		send_value(32'sh80000000, 24'hFFFFF5);
		send_value(32'sh80000000, 24'h000000);
		send_value(-32'sd2147483647, 24'hFFFFF4);
		send_value(32'sd1000000000, 24'hAAAAAA);
		send_value(32'sd999999999, 24'h555555);
		send_value(-32'sd999999999, 24'hFFFFFF);
		send_value(-32'sd1000000000, 24'hFFFFF0);
		send_value(32'sd123456789, 24'h0F0F0F);
		send_value(-32'sd5, 24'hF0F0F0);
		send_value(32'sh55555555, 24'hFFFFFB);
		send_value(32'shAAAAAAAA, 24'hFFFFF7);
		wait_drained();

		send_random(110);
		wait_drained();
		idle_pct = 88;
		send_random(110);
		wait_drained();
		idle_pct = 0;
		send_random(110);

		wait_drained();
		repeat (DrainCycles) @(posedge clk);
		if (board.pending() != 0)
			board.char_errors += board.pending();

		$display("converted %0d values (%0d negative, %0d near the position wrap)",
			values_sent, negatives_sent, wraps_sent);
		$display("checked %0d characters over three idling mixes, %0d faults",
			board.chars_checked, board.char_errors);
		if (board.char_errors == 0)
			$display("int32_to_decimal_text_test: done, clean");
		else
			$display("int32_to_decimal_text_test: done, errors");
		$finish;
	end

endmodule
